FILE: hdl/pmf_pkg.sv
// Shared types, codes and saturation helpers for the particle motion and fade core.
`default_nettype none
package pmf_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned DT_W    = 16;
   localparam int unsigned ALPHA_W = 17;
   localparam int unsigned OPA_W   = DATA_W + 1;
   localparam int unsigned OPB_W   = ALPHA_W;
   localparam int unsigned PROD_W  = OPA_W + OPB_W + 1;
   localparam int unsigned DVD_W   = DATA_W + ALPHA_W;
   localparam int unsigned QUO_W   = ALPHA_W;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned REG_W   = 3;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [OPA_W-1:0]  opa_type;
   typedef logic        [OPB_W-1:0]  opb_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic        [DVD_W-1:0]  dvd_type;
   typedef logic        [QUO_W-1:0]  quo_type;
   typedef logic        [REG_W-1:0]  reg_idx_type;

   localparam logic [1:0] PH_RUN  = 2'd0;
   localparam logic [1:0] PH_FADE = 2'd1;
   localparam logic [1:0] PH_DEAD = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

   localparam reg_idx_type REG_GRAVITY_X     = 3'd0;
   localparam reg_idx_type REG_GRAVITY_Y     = 3'd1;
   localparam reg_idx_type REG_GRAVITY_Z     = 3'd2;
   localparam reg_idx_type REG_LIFE_LIMIT    = 3'd3;
   localparam reg_idx_type REG_FADE_ENABLE   = 3'd4;
   localparam reg_idx_type REG_FADE_DURATION = 3'd5;
   localparam reg_idx_type REG_INITIAL_ALPHA = 3'd6;

   function automatic data_type sat32(input prod_type v);
      data_type r;
      if (!v[PROD_W-1] && (|v[PROD_W-2:DATA_W-1])) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[PROD_W-1] && !(&v[PROD_W-2:DATA_W-1])) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic data_type add_sat(input data_type a, input data_type b);
      logic signed [DATA_W:0] s;
      data_type r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pmf_mul_unit.sv
// Shared registered multiplier: signed 33-bit by unsigned 17-bit.
`default_nettype none
module pmf_mul_unit (
   input  wire logic             clock,
   input  wire pmf_pkg::opa_type op_a,
   input  wire pmf_pkg::opb_type op_b,
   output pmf_pkg::prod_type     product
);
   import pmf_pkg::*;

   prod_type product_ff;

   always_ff @(posedge clock) begin
      product_ff <= prod_type'(op_a) * prod_type'($signed({1'b0, op_b}));
   end

   assign product = product_ff;

endmodule
`default_nettype wire

FILE: hdl/pmf_div_unit.sv
// Restoring divider, one quotient bit per cycle; dividend high part must be below divisor.
`default_nettype none
module pmf_div_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pmf_pkg::dvd_type  dividend,
   input  wire logic [31:0]       divisor,
   output logic                   done,
   output pmf_pkg::quo_type       quotient
);
   import pmf_pkg::*;

   logic [DATA_W-1:0] rem_ff;
   quo_type           quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = (trial >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[DVD_W-1:QUO_W];
         quo_ff <= dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: hdl/particle_motion_and_fade_core.sv
// Top level: register port, sequencer and particle state for one Euler-integrated particle.
// Spawn goes straight to the done state. Tick: nine products through the one shared
// multiplier, each in a multiply and an accumulate state; in fade phase the divider
// then computes alpha unless it is spent. One item at a time; the next input transfer
// can be taken while the previous result still waits. Synchronous active-high reset
// clears sequencer and motion state; particle starts in run phase at origin, alpha zero.
`default_nettype none
module particle_motion_and_fade_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [15:0] req_delta_time,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic signed [31:0] req_start_z,
   input  wire logic signed [31:0] req_start_vel_x,
   input  wire logic signed [31:0] req_start_vel_y,
   input  wire logic signed [31:0] req_start_vel_z,
   input  wire logic signed [31:0] req_extra_force_x,
   input  wire logic signed [31:0] req_extra_force_y,
   input  wire logic signed [31:0] req_extra_force_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [16:0]      rsp_opacity,
   output logic [1:0]       rsp_phase,
   output logic             rsp_is_dead,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pmf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_TIME = 3'd3;
   localparam logic [2:0] S_FADE = 3'd4;
   localparam logic [2:0] S_PROD = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   // configuration
   data_type             grav_ff [3];
   logic [DATA_W-1:0]    life_limit_ff;
   logic                 fade_enable_ff;
   logic [DATA_W-1:0]    fade_duration_ff;
   logic [ALPHA_W-1:0]   initial_alpha_ff;
   reg_idx_type          reg_idx;
   logic                 csr_write;

   // particle state
   data_type             pos_ff [3];
   data_type             vel_ff [3];
   data_type             force_ff [3];
   logic [DT_W-1:0]      dt_ff;
   logic [DATA_W-1:0]    elapsed_ff;
   logic [1:0]           phase_ff;
   logic [ALPHA_W-1:0]   alpha_ff;
   logic                 dead_ff;

   // sequencer
   logic [2:0]           state_ff;
   logic [1:0]           axis_ff;
   logic [1:0]           op_ff;

   // result registers
   logic                 rsp_valid_ff;
   data_type             rsp_pos_ff [3];
   logic [ALPHA_W-1:0]   rsp_opacity_ff;
   logic [1:0]           rsp_phase_ff;
   logic                 rsp_dead_ff;

   // datapath
   opa_type              op_a;
   opb_type              op_b;
   data_type             op_sel;
   prod_type             product;
   prod_type             shifted;
   data_type             scaled;
   data_type             acc_base;
   data_type             acc_sum;
   logic [ALPHA_W-1:0]   alpha0;
   logic [DATA_W:0]      el_sum;
   logic [DATA_W-1:0]    el_new;
   logic                 div_start;
   logic                 div_done;
   quo_type              quotient;
   logic                 in_xfer;
   logic                 out_load;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0]       <= '0;
         grav_ff[1]       <= '0;
         grav_ff[2]       <= '0;
         life_limit_ff    <= 32'h0001_0000;
         fade_enable_ff   <= 1'b0;
         fade_duration_ff <= 32'h0001_0000;
         initial_alpha_ff <= ALPHA_ONE;
      end else if (csr_write) begin
         case (reg_idx)
            REG_GRAVITY_X:     grav_ff[0]       <= csr_pwdata;
            REG_GRAVITY_Y:     grav_ff[1]       <= csr_pwdata;
            REG_GRAVITY_Z:     grav_ff[2]       <= csr_pwdata;
            REG_LIFE_LIMIT:    life_limit_ff    <= csr_pwdata;
            REG_FADE_ENABLE:   fade_enable_ff   <= csr_pwdata[0];
            REG_FADE_DURATION: fade_duration_ff <= csr_pwdata;
            REG_INITIAL_ALPHA: initial_alpha_ff <= csr_pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRAVITY_X:     csr_prdata = grav_ff[0];
         REG_GRAVITY_Y:     csr_prdata = grav_ff[1];
         REG_GRAVITY_Z:     csr_prdata = grav_ff[2];
         REG_LIFE_LIMIT:    csr_prdata = life_limit_ff;
         REG_FADE_ENABLE:   csr_prdata = {31'd0, fade_enable_ff};
         REG_FADE_DURATION: csr_prdata = fade_duration_ff;
         REG_INITIAL_ALPHA: csr_prdata = {15'd0, initial_alpha_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign alpha0 = (initial_alpha_ff > ALPHA_ONE) ? ALPHA_ONE : initial_alpha_ff;

   // multiplier operand select
   always_comb begin
      case (op_ff)
         2'd0:    op_sel = grav_ff[axis_ff];
         2'd1:    op_sel = force_ff[axis_ff];
         default: op_sel = vel_ff[axis_ff];
      endcase
      if (state_ff == S_FADE) begin
         op_a = {1'b0, elapsed_ff};
         op_b = alpha0;
      end else begin
         op_a = {op_sel[DATA_W-1], op_sel};
         op_b = {1'b0, dt_ff};
      end
   end

   pmf_mul_unit u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign shifted  = product >>> FRAC_BITS;
   assign scaled   = sat32(shifted);
   assign acc_base = (op_ff == 2'd2) ? pos_ff[axis_ff] : vel_ff[axis_ff];
   assign acc_sum  = add_sat(acc_base, scaled);

   assign el_sum = {1'b0, elapsed_ff} + {{(DATA_W-DT_W+1){1'b0}}, dt_ff};
   assign el_new = el_sum[DATA_W] ? {DATA_W{1'b1}} : el_sum[DATA_W-1:0];

   assign div_start = (state_ff == S_PROD);

   pmf_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product[DVD_W-1:0]),
      .divisor  (fade_duration_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign in_xfer   = req_valid & req_ready;
   assign out_load  = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         axis_ff    <= '0;
         op_ff      <= '0;
         pos_ff[0]  <= '0;
         pos_ff[1]  <= '0;
         pos_ff[2]  <= '0;
         vel_ff[0]  <= '0;
         vel_ff[1]  <= '0;
         vel_ff[2]  <= '0;
         elapsed_ff <= '0;
         phase_ff   <= PH_RUN;
         alpha_ff   <= '0;
         dead_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (in_xfer) begin
                  axis_ff <= '0;
                  op_ff   <= '0;
                  if (req_action) begin
                     pos_ff[0]  <= req_start_x;
                     pos_ff[1]  <= req_start_y;
                     pos_ff[2]  <= req_start_z;
                     vel_ff[0]  <= req_start_vel_x;
                     vel_ff[1]  <= req_start_vel_y;
                     vel_ff[2]  <= req_start_vel_z;
                     elapsed_ff <= '0;
                     dead_ff    <= 1'b0;
                     phase_ff   <= PH_RUN;
                     alpha_ff   <= alpha0;
                     state_ff   <= S_DONE;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: state_ff <= S_ACC;
            S_ACC: begin
               if (op_ff == 2'd2) begin
                  pos_ff[axis_ff] <= acc_sum;
                  op_ff           <= '0;
                  if (axis_ff == 2'd2) begin
                     state_ff <= S_TIME;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= S_MUL;
                  end
               end else begin
                  vel_ff[axis_ff] <= acc_sum;
                  op_ff           <= op_ff + 1'b1;
                  state_ff        <= S_MUL;
               end
            end
            S_TIME: begin
               elapsed_ff <= el_new;
               state_ff   <= S_DONE;
               case (phase_ff)
                  PH_RUN: begin
                     if (el_new >= life_limit_ff) begin
                        if (fade_enable_ff) begin
                           phase_ff   <= PH_FADE;
                           elapsed_ff <= '0;
                        end else begin
                           phase_ff <= PH_DEAD;
                        end
                     end
                  end
                  PH_FADE: state_ff <= S_FADE;
                  default: begin
                     phase_ff <= PH_DEAD;
                     dead_ff  <= 1'b1;
                  end
               endcase
            end
            S_FADE: begin
               // alpha already spent: zero duration, zero start or timer at or past duration
               if ((fade_duration_ff == '0) || (alpha0 == '0) ||
                   (elapsed_ff >= fade_duration_ff)) begin
                  alpha_ff <= '0;
                  phase_ff <= PH_DEAD;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_PROD;
               end
            end
            S_PROD: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  alpha_ff <= alpha0 - quotient;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // tick operands held for the whole item
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         dt_ff       <= req_delta_time;
         force_ff[0] <= req_extra_force_x;
         force_ff[1] <= req_extra_force_y;
         force_ff[2] <= req_extra_force_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pos_ff[0]  <= pos_ff[0];
         rsp_pos_ff[1]  <= pos_ff[1];
         rsp_pos_ff[2]  <= pos_ff[2];
         rsp_opacity_ff <= alpha_ff;
         rsp_phase_ff   <= phase_ff;
         rsp_dead_ff    <= dead_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_ff[0];
   assign rsp_pos_y   = rsp_pos_ff[1];
   assign rsp_pos_z   = rsp_pos_ff[2];
   assign rsp_opacity = rsp_opacity_ff;
   assign rsp_phase   = rsp_phase_ff;
   assign rsp_is_dead = rsp_dead_ff;

endmodule
`default_nettype wire
